>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the forest classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

>>> design/rfv_pkg.sv
// Package with the constants, types and codes of the forest classifier.
`default_nettype none

package rfv_pkg;

   localparam int MAX_TREES      = 64;
   localparam int NODES_PER_TREE = 512;
   localparam int NUM_FEATURES   = 32;
   localparam int DEPTH_LIMIT    = 8;

   localparam int STORE_DEPTH = MAX_TREES * NODES_PER_TREE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TREE_CNT_W  = $clog2(MAX_TREES + 1);
   localparam int DEPTH_W     = (DEPTH_LIMIT > 0) ? $clog2(DEPTH_LIMIT + 1) : 1;
   localparam int FEAT_IDX_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

   localparam int SLOT_W  = 9;
   localparam int FEAT_W  = 5;
   localparam int VALUE_W = 32;
   localparam int VOTE_W  = 7;

   localparam logic signed [1:0] CLASS_NONE = 2'sb11;
   localparam logic signed [1:0] CLASS_ZERO = 2'sb00;
   localparam logic signed [1:0] CLASS_ONE  = 2'sb01;

   typedef enum logic [1:0] {
      OP_NODE_WRITE    = 2'd0,
      OP_FEATURE_WRITE = 2'd1,
      OP_CLASSIFY      = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_VOTE
   } walk_state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         right_slot;
      logic [SLOT_W-1:0]         left_slot;
      logic signed [VALUE_W-1:0] threshold;
      logic [FEAT_W-1:0]         feature;
      logic                      leaf_class;
      logic                      leaf_flag;
   } node_type;

   typedef struct packed {
      logic                      en;
      logic [FEAT_IDX_W-1:0]     idx;
      logic signed [VALUE_W-1:0] value;
   } samp_wr_type;

   typedef struct packed {
      logic              done;
      logic [VOTE_W-1:0] one;
      logic [VOTE_W-1:0] zero;
      logic [VOTE_W-1:0] invalid;
   } walk_result_type;

endpackage

`default_nettype wire

>>> design/rfv_node_mem.sv
// Node memory of the forest: one write port and one registered read port.
`default_nettype none

module rfv_node_mem
   import rfv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire node_type          wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output node_type               rd_data
);

   node_type mem [STORE_DEPTH];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/rfv_walker.sv
// Tree walk sequencer with the sample store, the split compare and the vote counters.
`default_nettype none

module rfv_walker
   import rfv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [TREE_CNT_W-1:0] n_trees,
   input  wire samp_wr_type           samp_wr,
   input  wire node_type              node_rd,
   input  wire logic                  rsp_free,
   output logic [ADDR_W-1:0]          rd_addr,
   output logic                       busy,
   output walk_result_type            wres
);

   walk_state_type state_ff, state_in;
   logic [TREE_CNT_W-1:0] tree_ff, tree_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [VOTE_W-1:0]     one_ff, one_in;
   logic [VOTE_W-1:0]     zero_ff, zero_in;
   logic [VOTE_W-1:0]     invalid_ff, invalid_in;

   logic signed [VALUE_W-1:0] sample_ff [NUM_FEATURES];

   logic                      feat_ok;
   logic signed [VALUE_W-1:0] sval;
   logic                      go_left;
   logic [SLOT_W-1:0]         next_slot;
   logic                      slot_ok;
   logic                      tree_end;
   logic [TREE_CNT_W-1:0]     tree_next;
   logic [TREE_CNT_W-1:0]     rd_tree;
   logic [SLOT_W-1:0]         rd_slot;

   always_ff @(posedge clock) begin
      if (samp_wr.en) begin
         sample_ff[samp_wr.idx] <= samp_wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tree_ff    <= '0;
         depth_ff   <= '0;
         one_ff     <= '0;
         zero_ff    <= '0;
         invalid_ff <= '0;
      end else begin
         state_ff   <= state_in;
         tree_ff    <= tree_in;
         depth_ff   <= depth_in;
         one_ff     <= one_in;
         zero_ff    <= zero_in;
         invalid_ff <= invalid_in;
      end
   end

   always_comb begin
      feat_ok   = 32'(node_rd.feature) < NUM_FEATURES;
      sval      = feat_ok ? sample_ff[FEAT_IDX_W'(node_rd.feature)] : '0;
      go_left   = sval <= node_rd.threshold;
      next_slot = go_left ? node_rd.left_slot : node_rd.right_slot;
      slot_ok   = 32'(next_slot) < NODES_PER_TREE;
      tree_end  = node_rd.leaf_flag || !slot_ok || (32'(depth_ff) == DEPTH_LIMIT);
      tree_next = tree_ff + TREE_CNT_W'(1);

      state_in     = state_ff;
      tree_in      = tree_ff;
      depth_in     = depth_ff;
      one_in       = one_ff;
      zero_in      = zero_ff;
      invalid_in   = invalid_ff;
      rd_tree      = tree_ff;
      rd_slot      = next_slot;
      wres.done    = 1'b0;
      wres.one     = one_ff;
      wres.zero    = zero_ff;
      wres.invalid = invalid_ff;

      case (state_ff)
         ST_IDLE: begin
            rd_tree = '0;
            rd_slot = '0;
            if (start) begin
               tree_in    = '0;
               depth_in   = '0;
               one_in     = '0;
               zero_in    = '0;
               invalid_in = '0;
               state_in   = (n_trees == '0) ? ST_VOTE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (tree_end) begin
               if (node_rd.leaf_flag && node_rd.leaf_class) begin
                  one_in = one_ff + VOTE_W'(1);
               end else if (node_rd.leaf_flag) begin
                  zero_in = zero_ff + VOTE_W'(1);
               end else begin
                  invalid_in = invalid_ff + VOTE_W'(1);
               end
               tree_in  = tree_next;
               depth_in = '0;
               rd_tree  = tree_next;
               rd_slot  = '0;
               if (tree_next == n_trees) begin
                  state_in = ST_VOTE;
               end
            end else begin
               depth_in = depth_ff + DEPTH_W'(1);
            end
         end
         ST_VOTE: begin
            wres.done = rsp_free;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_addr = ADDR_W'(rd_tree) * ADDR_W'(NODES_PER_TREE) + ADDR_W'(rd_slot);
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

>>> design/random_forest_vote_classifier_top.sv
// Top level of the random forest classifier: request decode, register, result register.
// Node and feature writes never raise req_stall, and the next transaction may follow at once.
// A classify transaction keeps req_stall raised until the result register and rsp_valid load;
// the walk reads one node per cycle over the active trees, at most min(active_trees, MAX_TREES)
// * (DEPTH_LIMIT + 1) nodes in all, and rsp_stall on a held result delays the load.
// Reset clears the control state, the register and rsp_valid; the stores are undefined.
`default_nettype none
`include "assert_macros.svh"

module random_forest_vote_classifier_top
   import rfv_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_operation,
   input  wire logic [5:0]                req_tree_select,
   input  wire logic [SLOT_W-1:0]         req_node_select,
   input  wire logic                      req_leaf_flag,
   input  wire logic                      req_leaf_class,
   input  wire logic [FEAT_W-1:0]         req_feature_select,
   input  wire logic signed [VALUE_W-1:0] req_threshold,
   input  wire logic [SLOT_W-1:0]         req_left_slot,
   input  wire logic [SLOT_W-1:0]         req_right_slot,
   input  wire logic signed [VALUE_W-1:0] req_feature_value,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [6:0]                csr_active_trees,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [1:0]              rsp_vote_class,
   output logic [VOTE_W-1:0]              rsp_votes_class_one,
   output logic [VOTE_W-1:0]              rsp_votes_class_zero,
   output logic [VOTE_W-1:0]              rsp_votes_invalid
);

   logic [6:0]               active_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [1:0]        class_ff, class_in;
   logic [VOTE_W-1:0]        one_ff, zero_ff, invalid_ff;

   logic                     req_acc;
   logic                     busy;
   logic                     start;
   logic                     node_wr_en;
   logic [ADDR_W-1:0]        node_wr_addr;
   node_type                 node_wr_data;
   node_type                 node_rd;
   logic [ADDR_W-1:0]        rd_addr;
   samp_wr_type              samp_wr;
   walk_result_type          wres;
   logic                     rsp_free;
   logic [TREE_CNT_W-1:0]    n_sat;
   logic [VOTE_W:0]          vote_sum;

   assign req_stall = busy;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign n_sat     = (32'(active_ff) > MAX_TREES) ? TREE_CNT_W'(MAX_TREES)
                                                   : TREE_CNT_W'(active_ff);

   always_comb begin
      start         = 1'b0;
      node_wr_en    = 1'b0;
      samp_wr.en    = 1'b0;
      samp_wr.idx   = FEAT_IDX_W'(req_feature_select);
      samp_wr.value = req_feature_value;
      case (op_type'(req_operation))
         OP_NODE_WRITE: begin
            node_wr_en = req_acc && (32'(req_tree_select) < MAX_TREES)
                         && (32'(req_node_select) < NODES_PER_TREE);
         end
         OP_FEATURE_WRITE: begin
            samp_wr.en = req_acc && (32'(req_feature_select) < NUM_FEATURES);
         end
         OP_CLASSIFY: begin
            start = req_acc;
         end
         default: begin
            start = 1'b0;
         end
      endcase
   end

   assign node_wr_addr = ADDR_W'(req_tree_select) * ADDR_W'(NODES_PER_TREE)
                         + ADDR_W'(req_node_select);

   always_comb begin
      node_wr_data.right_slot = req_right_slot;
      node_wr_data.left_slot  = req_left_slot;
      node_wr_data.threshold  = req_threshold;
      node_wr_data.feature    = req_feature_select;
      node_wr_data.leaf_class = req_leaf_class;
      node_wr_data.leaf_flag  = req_leaf_flag;
   end

   rfv_node_mem u_node_mem (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_addr (rd_addr),
      .rd_data (node_rd)
   );

   rfv_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .n_trees  (n_sat),
      .samp_wr  (samp_wr),
      .node_rd  (node_rd),
      .rsp_free (rsp_free),
      .rd_addr  (rd_addr),
      .busy     (busy),
      .wres     (wres)
   );

   always_comb begin
      if (wres.invalid >= wres.zero && wres.invalid >= wres.one) begin
         class_in = CLASS_NONE;
      end else if (wres.zero >= wres.one) begin
         class_in = CLASS_ZERO;
      end else begin
         class_in = CLASS_ONE;
      end
      rsp_valid_in = rsp_valid_ff;
      if (wres.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_active_trees;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wres.done) begin
         class_ff   <= class_in;
         one_ff     <= wres.one;
         zero_ff    <= wres.zero;
         invalid_ff <= wres.invalid;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_vote_class       = class_ff;
   assign rsp_votes_class_one  = one_ff;
   assign rsp_votes_class_zero = zero_ff;
   assign rsp_votes_invalid    = invalid_ff;

   assign vote_sum = {1'b0, wres.one} + {1'b0, wres.zero} + {1'b0, wres.invalid};

   `ASSERT_IMPLIES(a_vote_total, clock, reset, wres.done, vote_sum == (VOTE_W + 1)'(n_sat))
   `ASSERT_NEXT(a_done_loads_rsp, clock, reset, wres.done, rsp_valid_ff)
   `ASSERT_NEXT(a_start_stalls, clock, reset, start && n_sat != '0, req_stall)
   `ASSERT_IMPLIES(a_done_when_free, clock, reset, wres.done, rsp_free && busy)

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the random forest majority-vote classifier.
`timescale 1ns / 100ps

module tb_top
   import rfv_pkg::*;
();

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int PHASE_ITEMS    = 135;
   localparam int HOLD_AFTER     = 30;
   localparam int HOLD_CYCLES    = 2000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int END_WAIT       = 600;
   localparam int PHASE_WAIT     = 16;

   typedef struct {
      logic [1:0]                op;
      logic [5:0]                tree;
      logic [SLOT_W-1:0]         slot;
      logic                      leaf;
      logic                      cls;
      logic [FEAT_W-1:0]         feat;
      logic signed [VALUE_W-1:0] thr;
      logic [SLOT_W-1:0]         left;
      logic [SLOT_W-1:0]         right;
      logic signed [VALUE_W-1:0] value;
   } forest_req_type;

   typedef struct {
      logic signed [1:0] cls;
      logic [VOTE_W-1:0] one;
      logic [VOTE_W-1:0] zero;
      logic [VOTE_W-1:0] invalid;
   } vote_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_operation = '0;
   logic [5:0]                req_tree_select = '0;
   logic [SLOT_W-1:0]         req_node_select = '0;
   logic                      req_leaf_flag = 1'b0;
   logic                      req_leaf_class = 1'b0;
   logic [FEAT_W-1:0]         req_feature_select = '0;
   logic signed [VALUE_W-1:0] req_threshold = '0;
   logic [SLOT_W-1:0]         req_left_slot = '0;
   logic [SLOT_W-1:0]         req_right_slot = '0;
   logic signed [VALUE_W-1:0] req_feature_value = '0;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [6:0]                csr_active_trees = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [1:0]         rsp_vote_class;
   logic [VOTE_W-1:0]         rsp_votes_class_one;
   logic [VOTE_W-1:0]         rsp_votes_class_zero;
   logic [VOTE_W-1:0]         rsp_votes_invalid;

   random_forest_vote_classifier_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_tree_select      (req_tree_select),
      .req_node_select      (req_node_select),
      .req_leaf_flag        (req_leaf_flag),
      .req_leaf_class       (req_leaf_class),
      .req_feature_select   (req_feature_select),
      .req_threshold        (req_threshold),
      .req_left_slot        (req_left_slot),
      .req_right_slot       (req_right_slot),
      .req_feature_value    (req_feature_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_active_trees     (csr_active_trees),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_vote_class       (rsp_vote_class),
      .rsp_votes_class_one  (rsp_votes_class_one),
      .rsp_votes_class_zero (rsp_votes_class_zero),
      .rsp_votes_invalid    (rsp_votes_invalid)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model of the forest as the block should hold it, updated per accepted transaction.
   node_type                  tree_nodes [STORE_DEPTH];
   logic signed [VALUE_W-1:0] sample_vals [NUM_FEATURES];
   int unsigned               forest_size = 0;
   vote_result_type           vote_results_due [$];

   // Planning copy of the stores, updated as requests are queued.
   node_type                  plan_nodes [STORE_DEPTH];
   bit                        plan_node_known [STORE_DEPTH];
   logic signed [VALUE_W-1:0] plan_samples [NUM_FEATURES];
   bit                        plan_sample_known [NUM_FEATURES];
   int                        plan_trees = 0;

   forest_req_type pending_requests [$];
   forest_req_type cur_req;
   bit          sending = 1'b0;
   int          send_wait = 0;
   bit          send_burst = 1'b0;
   int          rsp_wait = 0;
   bit          rsp_burst = 1'b0;
   int          held_cycles = 0;
   int unsigned quiet_cycles = 0;

   int queued_items = 0;
   int mismatches = 0;
   int results_checked = 0;
   int settings_used = 0;
   int node_writes = 0;
   int feature_writes = 0;
   int classifies = 0;
   int ignored = 0;
   int total_one = 0;
   int total_zero = 0;
   int total_invalid = 0;

   function automatic node_type item_node(input forest_req_type it);
      node_type nd;
      nd.leaf_flag  = it.leaf;
      nd.leaf_class = it.cls;
      nd.feature    = it.feat;
      nd.threshold  = it.thr;
      nd.left_slot  = it.left;
      nd.right_slot = it.right;
      return nd;
   endfunction

   function automatic node_type mk_node(input logic leaf, input logic cls,
                                        input logic [FEAT_W-1:0] feat,
                                        input logic signed [VALUE_W-1:0] thr,
                                        input logic [SLOT_W-1:0] left,
                                        input logic [SLOT_W-1:0] right);
      node_type nd;
      nd.leaf_flag  = leaf;
      nd.leaf_class = cls;
      nd.feature    = feat;
      nd.threshold  = thr;
      nd.left_slot  = left;
      nd.right_slot = right;
      return nd;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_q16();
      case ($urandom_range(0, 5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return $signed($urandom_range(0, 32'h1_ffff)) - 32'sh1_0000;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot();
      if ($urandom_range(0, 4) != 0)
         return SLOT_W'($urandom_range(0, 15));
      return SLOT_W'($urandom_range(0, NODES_PER_TREE - 1));
   endfunction

   function automatic node_type rand_node();
      return mk_node($urandom_range(0, 9) < 4, 1'($urandom_range(0, 1)),
                     FEAT_W'($urandom_range(0, NUM_FEATURES - 1)), pick_q16(),
                     pick_slot(), pick_slot());
   endfunction

   function automatic forest_req_type rand_item();
      forest_req_type it;
      it.op    = 2'($urandom_range(0, 3));
      it.tree  = 6'($urandom_range(0, 63));
      it.slot  = SLOT_W'($urandom_range(0, NODES_PER_TREE - 1));
      it.leaf  = 1'($urandom_range(0, 1));
      it.cls   = 1'($urandom_range(0, 1));
      it.feat  = FEAT_W'($urandom_range(0, 31));
      it.thr   = $signed($urandom);
      it.left  = SLOT_W'($urandom_range(0, NODES_PER_TREE - 1));
      it.right = SLOT_W'($urandom_range(0, NODES_PER_TREE - 1));
      it.value = $signed($urandom);
      return it;
   endfunction

   function automatic int tree_vote(input int unsigned tree);
      int unsigned               slot;
      node_type                  nd;
      logic signed [VALUE_W-1:0] val;
      logic [SLOT_W-1:0]         nxt;
      slot = 0;
      for (int d = 0; d <= DEPTH_LIMIT; d++) begin
         nd = tree_nodes[tree * NODES_PER_TREE + slot];
         if (nd.leaf_flag)
            return int'(nd.leaf_class);
         val = (nd.feature < NUM_FEATURES) ? sample_vals[nd.feature] : 32'sd0;
         nxt = (val <= nd.threshold) ? nd.left_slot : nd.right_slot;
         if (nxt >= NODES_PER_TREE)
            return -1;
         slot = 32'(nxt);
      end
      return -1;
   endfunction

   task automatic update_forest_model(input forest_req_type it);
      vote_result_type vr;
      int unsigned  n;
      int           v;
      int           v0;
      int           v1;
      int           vi;
      case (it.op)
         OP_NODE_WRITE: begin
            node_writes++;
            if (it.tree < MAX_TREES && it.slot < NODES_PER_TREE)
               tree_nodes[it.tree * NODES_PER_TREE + it.slot] = item_node(it);
         end
         OP_FEATURE_WRITE: begin
            feature_writes++;
            if (it.feat < NUM_FEATURES)
               sample_vals[it.feat] = it.value;
         end
         OP_CLASSIFY: begin
            classifies++;
            n = (forest_size > MAX_TREES) ? MAX_TREES : forest_size;
            v0 = 0;
            v1 = 0;
            vi = 0;
            for (int t = 0; t < n; t++) begin
               v = tree_vote(t);
               if (v == 1)
                  v1++;
               else if (v == 0)
                  v0++;
               else
                  vi++;
            end
            if (vi >= v0 && vi >= v1)
               vr.cls = CLASS_NONE;
            else if (v0 >= v1)
               vr.cls = CLASS_ZERO;
            else
               vr.cls = CLASS_ONE;
            vr.one     = VOTE_W'(v1);
            vr.zero    = VOTE_W'(v0);
            vr.invalid = VOTE_W'(vi);
            total_one     += v1;
            total_zero    += v0;
            total_invalid += vi;
            vote_results_due = {vote_results_due, vr};
         end
         default: ignored++;
      endcase
   endtask

   task automatic push_req(input forest_req_type it);
      if (it.op == OP_NODE_WRITE) begin
         plan_nodes[it.tree * NODES_PER_TREE + it.slot]      = item_node(it);
         plan_node_known[it.tree * NODES_PER_TREE + it.slot] = 1'b1;
      end else if (it.op == OP_FEATURE_WRITE) begin
         plan_samples[it.feat]      = it.value;
         plan_sample_known[it.feat] = 1'b1;
      end
      queued_items++;
      pending_requests = {pending_requests, it};
   endtask

   task automatic push_node(input logic [5:0] tree, input logic [SLOT_W-1:0] slot,
                            input node_type nd);
      forest_req_type it;
      it       = rand_item();
      it.op    = OP_NODE_WRITE;
      it.tree  = tree;
      it.slot  = slot;
      it.leaf  = nd.leaf_flag;
      it.cls   = nd.leaf_class;
      it.feat  = nd.feature;
      it.thr   = nd.threshold;
      it.left  = nd.left_slot;
      it.right = nd.right_slot;
      push_req(it);
   endtask

   task automatic push_feature(input logic [FEAT_W-1:0] feat,
                               input logic signed [VALUE_W-1:0] value);
      forest_req_type it;
      it       = rand_item();
      it.op    = OP_FEATURE_WRITE;
      it.feat  = feat;
      it.value = value;
      push_req(it);
   endtask

   task automatic push_ignored();
      forest_req_type it;
      it    = rand_item();
      it.op = OP_IGNORED;
      push_req(it);
   endtask

   // Writes whatever node or feature the active trees would reach unwritten, then classifies.
   task automatic push_classify();
      forest_req_type    it;
      int unsigned       slot;
      int unsigned       idx;
      node_type          nd;
      bit                clean;
      for (int t = 0; t < plan_trees; t++) begin
         clean = 1'b0;
         while (!clean) begin
            clean = 1'b1;
            slot  = 0;
            for (int d = 0; d <= DEPTH_LIMIT; d++) begin
               idx = t * NODES_PER_TREE + slot;
               if (!plan_node_known[idx]) begin
                  push_node(6'(t), SLOT_W'(slot), rand_node());
                  clean = 1'b0;
                  break;
               end
               nd = plan_nodes[idx];
               if (nd.leaf_flag)
                  break;
               if (!plan_sample_known[nd.feature])
                  push_feature(nd.feature, pick_q16());
               slot = (plan_samples[nd.feature] <= nd.threshold) ? 32'(nd.left_slot)
                                                                  : 32'(nd.right_slot);
            end
         end
      end
      it    = rand_item();
      it.op = OP_CLASSIFY;
      push_req(it);
   endtask

   task automatic drain(input int extra);
      while (pending_requests.size() != 0 || sending || vote_results_due.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_forest_size(input logic [6:0] trees);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_active_trees <= trees;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid   <= 1'b0;
      forest_size = 32'(trees);
      plan_trees  = (trees > MAX_TREES) ? MAX_TREES : 32'(trees);
      settings_used++;
   endtask

   task automatic run_random_phase(input int count);
      int stop_at;
      int r;
      stop_at = queued_items + count;
      while (queued_items < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            if (plan_trees > 0 && $urandom_range(0, 3) != 0)
               push_node(6'($urandom_range(0, plan_trees - 1)), pick_slot(), rand_node());
            else
               push_node(6'($urandom_range(0, 63)), pick_slot(), rand_node());
         end else if (r < 60) begin
            push_feature(FEAT_W'($urandom_range(0, NUM_FEATURES - 1)), pick_q16());
         end else if (r < 92) begin
            push_classify();
         end else begin
            push_ignored();
         end
      end
   endtask

   task automatic report_field(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sending   = 1'b0;
         send_wait = 0;
      end else begin
         if (sending && !req_stall) begin
            update_forest_model(cur_req);
            sending = 1'b0;
            if ($urandom_range(0, 39) == 0)
               send_burst = !send_burst;
            send_wait = send_burst ? 0 : $urandom_range(0, 10);
         end
         if (!sending) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_requests.size() != 0) begin
               cur_req = pending_requests.pop_front();
               sending = 1'b1;
               req_operation      <= cur_req.op;
               req_tree_select    <= cur_req.tree;
               req_node_select    <= cur_req.slot;
               req_leaf_flag      <= cur_req.leaf;
               req_leaf_class     <= cur_req.cls;
               req_feature_select <= cur_req.feat;
               req_threshold      <= cur_req.thr;
               req_left_slot      <= cur_req.left;
               req_right_slot     <= cur_req.right;
               req_feature_value  <= cur_req.value;
            end
         end
         req_valid <= sending;
      end
   end

   always @(posedge clock) begin
      vote_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (vote_results_due.size() == 0) begin
               $display("%0t: unexpected vote result, class %0d one %0d zero %0d invalid %0d",
                        $time, rsp_vote_class, rsp_votes_class_one,
                        rsp_votes_class_zero, rsp_votes_invalid);
               mismatches++;
            end else begin
               want = vote_results_due.pop_front();
               if (rsp_vote_class !== want.cls)
                  report_field("vote_class", want.cls, rsp_vote_class);
               if (rsp_votes_class_one !== want.one)
                  report_field("votes_class_one", want.one, rsp_votes_class_one);
               if (rsp_votes_class_zero !== want.zero)
                  report_field("votes_class_zero", want.zero, rsp_votes_class_zero);
               if (rsp_votes_invalid !== want.invalid)
                  report_field("votes_invalid", want.invalid, rsp_votes_invalid);
            end
            results_checked++;
            if ($urandom_range(0, 39) == 0)
               rsp_burst = !rsp_burst;
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 10);
            if (results_checked == HOLD_AFTER) begin
               rsp_wait    = HOLD_CYCLES;
               held_cycles = HOLD_CYCLES;
            end
         end
         rsp_stall <= (rsp_wait > 0);
         if (rsp_wait > 0)
            rsp_wait--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("random_forest_vote_classifier_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [6:0] tree_counts [8];
      tree_counts = '{7'd1, 7'd7, 7'd64, 7'd127, 7'd20, 7'd2, 7'd45, 7'd64};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_forest_size(7'd0);
      push_classify();
      push_ignored();
      push_feature(5'd0, 32'sh8000_0000);
      push_feature(5'd31, 32'sh7fff_ffff);
      push_node(6'd63, 9'd511, mk_node(1'b0, 1'b1, 5'd31, 32'sh7fff_ffff, 9'd511, 9'd511));
      push_node(6'd0, 9'd0, mk_node(1'b1, 1'b1, 5'd0, 32'sd0, 9'd0, 9'd0));
      push_classify();
      drain(PHASE_WAIT);

      write_forest_size(7'd3);
      push_node(6'd1, 9'd0, mk_node(1'b0, 1'b0, 5'd0, 32'sh8000_0000, 9'd511, 9'd1));
      push_node(6'd1, 9'd511, mk_node(1'b1, 1'b0, 5'd0, 32'sd0, 9'd0, 9'd0));
      push_node(6'd2, 9'd0, mk_node(1'b0, 1'b0, 5'd31, 32'sh7fff_ffff, 9'd0, 9'd0));
      push_classify();
      push_node(6'd2, 9'd0, mk_node(1'b1, 1'b1, 5'd0, 32'sd0, 9'd0, 9'd0));
      push_classify();
      push_node(6'd0, 9'd0, mk_node(1'b1, 1'b0, 5'd0, 32'sd0, 9'd0, 9'd0));
      push_classify();
      drain(PHASE_WAIT);

      foreach (tree_counts[i]) begin
         write_forest_size(tree_counts[i]);
         run_random_phase(PHASE_ITEMS);
         drain(PHASE_WAIT);
      end
      drain(END_WAIT);

      $display("Covered %0d node writes, %0d feature writes, %0d classifications and %0d",
               node_writes, feature_writes, classifies, ignored);
      $display("ignored requests over %0d tree counts, a %0d-cycle result hold, votes %0d/%0d/%0d.",
               settings_used, held_cycles, total_one, total_zero, total_invalid);
      if (mismatches == 0)
         $display("random_forest_vote_classifier_top regression: pass");
      else
         $display("random_forest_vote_classifier_top regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/rfv_pkg.sv
design/rfv_node_mem.sv
design/rfv_walker.sv
design/random_forest_vote_classifier_top.sv
sim/tb_top.sv
